>>> rtl/vtpa_pkg.sv
package vtpa_pkg;

    // Quarter-wave sine table, Q14, 64 steps from zero to a right angle.
    localparam logic [15:0] QSIN [0:64] = '{
        16'd0, 16'd402, 16'd804, 16'd1205, 16'd1606, 16'd2006, 16'd2404, 16'd2801,
        16'd3196, 16'd3590, 16'd3981, 16'd4370, 16'd4756, 16'd5139, 16'd5520,
        16'd5897, 16'd6270, 16'd6639, 16'd7005, 16'd7366, 16'd7723, 16'd8076,
        16'd8423, 16'd8765, 16'd9102, 16'd9434, 16'd9760, 16'd10080, 16'd10394,
        16'd10702, 16'd11003, 16'd11297, 16'd11585, 16'd11866, 16'd12140,
        16'd12406, 16'd12665, 16'd12916, 16'd13160, 16'd13395, 16'd13623,
        16'd13842, 16'd14053, 16'd14256, 16'd14449, 16'd14635, 16'd14811,
        16'd14978, 16'd15137, 16'd15286, 16'd15426, 16'd15557, 16'd15679,
        16'd15791, 16'd15893, 16'd15986, 16'd16069, 16'd16143, 16'd16207,
        16'd16261, 16'd16305, 16'd16340, 16'd16364, 16'd16379, 16'd16384
    };

    localparam int          QUARTER     = 64;
    localparam int          SCALE_SHIFT = 6;
    localparam int          SMALL_LIMIT = 255;
    localparam logic [15:0] RAD_TO_BAM  = 16'd10430;
    localparam int          DIV_BITS    = 32;
    localparam int          DIV_STEP    = 4;
    localparam int          DEN_BITS    = 15;

    typedef struct packed {
        logic               op;
        logic               sc;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         theta;
    } vtpa_rot_t;

    typedef struct packed {
        logic [15:0]         angle;
        logic                div_en;
        logic                neg;
        logic [15:0]         x;
        logic [15:0]         y;
        logic [15:0]         rem;
        logic [DIV_BITS-1:0] num;
        logic [DEN_BITS-1:0] den;
    } vtpa_div_t;

endpackage

>>> rtl/vtpa_rot.sv
module vtpa_rot #(
    parameter int K = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vtpa_pkg::vtpa_rot_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vtpa_pkg::vtpa_rot_t out_data
);
    import vtpa_pkg::*;

    localparam int          MAG   = QUARTER >> K;
    localparam logic [15:0] S_MAG = QSIN[MAG];
    localparam logic [15:0] C_MAG = QSIN[QUARTER - MAG];
    localparam logic [7:0]  MASK  = 8'(MAG - 1);

    logic               v_reg;
    vtpa_rot_t          d_reg;
    vtpa_rot_t          d_next;
    logic               cw;
    logic signed [15:0] s_val;
    logic signed [15:0] c_val;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic [7:0]         rot;

    // Clockwise turn while y is positive; the sine term flips sign with it.
    always_comb
    begin
        cw     = (in_data.y > 16'sd0);
        c_val  = $signed(C_MAG);
        s_val  = cw ? -$signed(S_MAG) : $signed(S_MAG);
        rot    = cw ? 8'(-MAG) : 8'(MAG);
        sum_x  = c_val * in_data.x - s_val * in_data.y;
        sum_y  = s_val * in_data.x + c_val * in_data.y;
        d_next = in_data;
        d_next.x     = sum_x[29:14];
        d_next.y     = sum_y[29:14];
        d_next.theta = in_data.theta + rot;
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid) else $error("rotation stage lost a word");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("rotation stage changed a stalled word");
    a_theta: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.theta & MASK) == 8'd0)
        else $error("angle accumulator has bits below the step size");

endmodule

>>> rtl/vtpa_div.sv
module vtpa_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  vtpa_pkg::vtpa_div_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output vtpa_pkg::vtpa_div_t out_data
);
    import vtpa_pkg::*;

    logic      v_reg;
    vtpa_div_t d_reg;
    vtpa_div_t d_next;

    // Restoring division, four quotient bits shifted into num per stage.
    always_comb
    begin
        d_next = in_data;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            d_next.rem = {d_next.rem[14:0], d_next.num[DIV_BITS-1]};
            d_next.num = {d_next.num[DIV_BITS-2:0], 1'b0};
            if (d_next.rem >= {1'b0, d_next.den})
            begin
                d_next.rem    = d_next.rem - {1'b0, d_next.den};
                d_next.num[0] = 1'b1;
            end
        end
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            d_reg <= d_next;
    end

endmodule

>>> rtl/vector_to_polar_angle.sv
// Vector to polar angle: each word carries a signed 16-bit vector and an op bit, and
// yields its binary angle plus the vector turned onto the positive x axis.  Op 0 gives
// an 8-bit angle (sign-extended, 128 means pi), op 1 a 16-bit angle (32768 means pi)
// refined by 10430*y/x when the final x is positive.  Vectors with both components
// strictly inside +/-255 are scaled by 64 for precision and shifted back at the end.
// The block is a fully pipelined stream: one word per cycle is taken and delivered
// while m_tready is high.  The stages are one prescale stage, one stage per rotation,
// one setup stage for the divider, eight divider stages of four quotient bits each,
// and the output register.  Each stage holds its word under backpressure, so stalls
// only fill bubbles and never drop or repeat a word.
module vector_to_polar_angle #(
    parameter int ROTATION_STEPS = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op [0], x_in [16:1], y_in [32:17], zero [39:33]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // angle [15:0], x_out [31:16], y_out [47:32]
);
    import vtpa_pkg::*;

    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;

    // Prescale stage.
    logic               pre_v_reg;
    vtpa_rot_t          pre_d_reg;
    vtpa_rot_t          pre_next;
    logic signed [15:0] xi;
    logic signed [15:0] yi;

    // Both bounds are signed so that negative components are tested correctly.
    always_comb
    begin
        xi = $signed(s_tdata[16:1]);
        yi = $signed(s_tdata[32:17]);
        pre_next.op    = s_tdata[0];
        pre_next.sc    = (xi < $signed(16'(SMALL_LIMIT))) &&
                         (xi > -$signed(16'(SMALL_LIMIT))) &&
                         (yi < $signed(16'(SMALL_LIMIT))) &&
                         (yi > -$signed(16'(SMALL_LIMIT)));
        pre_next.x     = pre_next.sc ? (xi <<< SCALE_SHIFT) : xi;
        pre_next.y     = pre_next.sc ? (yi <<< SCALE_SHIFT) : yi;
        pre_next.theta = 8'd0;
    end

    logic rot_v   [0:ROTATION_STEPS];
    logic rot_rdy [0:ROTATION_STEPS];
    vtpa_rot_t rot_d [0:ROTATION_STEPS];

    assign s_tready   = !pre_v_reg || rot_rdy[0];
    assign rot_v[0]   = pre_v_reg;
    assign rot_d[0]   = pre_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_v_reg <= 1'b0;
        else if (s_tready)
            pre_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            pre_d_reg <= pre_next;
    end

    for (genvar k = 0; k < ROTATION_STEPS; k++)
    begin : g_rot
        vtpa_rot #(.K(k)) u_rot (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (rot_v[k]),
            .in_ready  (rot_rdy[k]),
            .in_data   (rot_d[k]),
            .out_valid (rot_v[k+1]),
            .out_ready (rot_rdy[k+1]),
            .out_data  (rot_d[k+1])
        );
    end

    // Setup stage: final angle byte, divider operands and the scale-back shift.
    vtpa_rot_t          r;
    vtpa_div_t          fin_next;
    logic               fin_v_reg;
    vtpa_div_t          fin_d_reg;
    logic [7:0]         th;
    logic [7:0]         a8;
    logic signed [31:0] prod;

    always_comb
    begin
        r    = rot_d[ROTATION_STEPS];
        th   = (!r.op && r.y > 16'sd0) ? r.theta - 8'd1 : r.theta;
        a8   = -th;
        prod = $signed({16'd0, RAD_TO_BAM}) * r.y;
        fin_next.angle  = r.op ? {a8, 8'd0} : {{8{a8[7]}}, a8};
        fin_next.div_en = r.op && (r.x > 16'sd0);
        fin_next.neg    = prod[31];
        fin_next.num    = prod[31] ? DIV_BITS'(-prod) : DIV_BITS'(prod);
        fin_next.den    = r.x[DEN_BITS-1:0];
        fin_next.rem    = 16'd0;
        fin_next.x      = r.sc ? 16'(r.x >>> SCALE_SHIFT) : r.x;
        fin_next.y      = r.sc ? 16'(r.y >>> SCALE_SHIFT) : r.y;
    end

    logic      div_v   [0:DIV_STAGES];
    logic      div_rdy [0:DIV_STAGES];
    vtpa_div_t div_d   [0:DIV_STAGES];

    assign rot_rdy[ROTATION_STEPS] = !fin_v_reg || div_rdy[0];
    assign div_v[0] = fin_v_reg;
    assign div_d[0] = fin_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_v_reg <= 1'b0;
        else if (rot_rdy[ROTATION_STEPS])
            fin_v_reg <= rot_v[ROTATION_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (rot_rdy[ROTATION_STEPS] && rot_v[ROTATION_STEPS])
            fin_d_reg <= fin_next;
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        vtpa_div u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (div_v[j]),
            .in_ready  (div_rdy[j]),
            .in_data   (div_d[j]),
            .out_valid (div_v[j+1]),
            .out_ready (div_rdy[j+1]),
            .out_data  (div_d[j+1])
        );
    end

    // Output register: apply the signed, truncated quotient to the angle.
    vtpa_div_t   q;
    logic [15:0] q16;
    logic        out_v_reg;
    logic [47:0] out_d_reg;
    logic [47:0] out_next;

    always_comb
    begin
        q        = div_d[DIV_STAGES];
        q16      = q.neg ? -q.num[15:0] : q.num[15:0];
        out_next = {q.y, q.x, q.angle + (q.div_en ? q16 : 16'd0)};
    end

    assign div_rdy[DIV_STAGES] = !out_v_reg || m_tready;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (div_rdy[DIV_STAGES])
            out_v_reg <= div_v[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (div_rdy[DIV_STAGES] && div_v[DIV_STAGES])
            out_d_reg <= out_next;
    end

endmodule

>>> dv/vector_to_polar_angle_tb.sv
module vector_to_polar_angle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // PIPE_LATENCY is the latency of the block at the default ROTATION_STEPS setting.
    localparam int PIPE_LATENCY = 18;
    localparam int CYCLE_LIMIT  = 400000;

    // Packed from the top bit down, so angle lands in the lowest bits of the word.
    typedef struct packed {
        logic signed [15:0] y_out;
        logic signed [15:0] x_out;
        logic signed [15:0] angle;
    } polar_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // op [0], x_in [16:1], y_in [32:17], zero [39:33]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // angle [15:0], x_out [31:16], y_out [47:32]

    // Idle rates in percent for the sender and the receiver, changed per phase.
    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int word_count;
    int result_count;
    int cycle_count;

    // Results the block still owes, oldest first.
    polar_t pending_polar[$];

    vector_to_polar_angle u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Folds the binary angle onto the quarter wave and applies the sign of the angle
    // to the table entry.
    function automatic int bam_sine(input int ang);
        int mag;
        int idx;
        int s;
        mag = (ang < 0) ? -ang : ang;
        idx = (mag > 64) ? 128 - mag : mag;
        s = int'(vtpa_pkg::QSIN[idx]);
        return (ang < 0) ? -s : s;
    endfunction

    // Keeps the high signed half of the product sum after a left shift by two.
    function automatic logic signed [15:0] rotate_high(input longint sum);
        logic [31:0] acc;
        acc = sum[31:0];
        acc = acc << 2;
        return acc[31:16];
    endfunction

    // Computes the angle and the rotated vector for one input word.
    function automatic polar_t polar_of(input logic op, input logic signed [15:0] x_in,
                                        input logic signed [15:0] y_in);
        int          x;
        int          y;
        int          nx;
        int          ny;
        int          rot;
        int          s;
        int          c;
        int          scale;
        logic [7:0]  theta;
        logic [7:0]  neg8;
        logic [15:0] t16;
        longint      quot;
        polar_t      res;
        x = int'(x_in);
        y = int'(y_in);
        scale = 0;
        theta = 8'd0;
        if (x < 255 && x > -255 && y < 255 && y > -255)
        begin
            scale = 6;
            x = x * 64;
            y = y * 64;
        end
        for (int k = 0; k < 7; k++)
        begin
            rot = 64 >> k;
            if (y > 0)
                rot = -rot;
            s = bam_sine(rot);
            c = bam_sine(int'($signed(8'(rot + 64))));
            nx = int'(rotate_high(longint'(c) * x - longint'(s) * y));
            ny = int'(rotate_high(longint'(s) * x + longint'(c) * y));
            x = nx;
            y = ny;
            theta = theta + 8'(rot);
        end
        if (op == 1'b0)
        begin
            if (y > 0)
                theta = theta - 8'd1;
            neg8 = -theta;
            res.angle = {{8{neg8[7]}}, neg8};
        end
        else
        begin
            neg8 = -theta;
            t16 = {neg8, 8'd0};
            if (x > 0)
            begin
                quot = (longint'(10430) * y) / x;
                t16 = t16 + quot[15:0];
            end
            res.angle = t16;
        end
        res.x_out = 16'(x >>> scale);
        res.y_out = 16'(y >>> scale);
        return res;
    endfunction

    // Sends one word, idling beforehand at the sender's current rate. Valid stays
    // high after an acceptance so that words can follow back to back.
    task automatic send_vector(input logic op, input logic [15:0] x_in,
                               input logic [15:0] y_in);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, y_in, x_in, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_polar.push_back(polar_of(op, x_in, y_in));
        word_count++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every result owed has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_polar.size() != 0)
            @(negedge clk);
    endtask

    // Checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        polar_t got;
        polar_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            result_count++;
            if (pending_polar.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_polar.pop_front();
                if (got.angle !== want.angle)
                begin
                    $display("%0t: angle expected %0d actual %0d", $time, want.angle,
                             got.angle);
                    error_count++;
                end
                if (got.x_out !== want.x_out)
                begin
                    $display("%0t: x_out expected %0d actual %0d", $time, want.x_out,
                             got.x_out);
                    error_count++;
                end
                if (got.y_out !== want.y_out)
                begin
                    $display("%0t: y_out expected %0d actual %0d", $time, want.y_out,
                             got.y_out);
                    error_count++;
                end
            end
        end
    end

    // The receiver stalls at its current rate; a new choice is made every cycle.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung pipeline must not stall the run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Extremes of both components, the axes, the scaling boundary at +/-255 and
    // the zero vector, each with both ops.
    task automatic test_directed();
        logic [15:0] corners [12];
        corners = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h0001, 16'd254,
                    -16'sd254, 16'd255, -16'sd255, 16'd1000, 16'h5555, 16'hAAAA};
        for (int i = 0; i < 12; i++)
            send_vector(i[0], corners[i], corners[11 - i]);
        send_vector(1'b0, 16'h0000, 16'h0000);
        send_vector(1'b1, 16'h0000, 16'h0000);
        send_vector(1'b1, 16'h8000, 16'h8000);
        send_vector(1'b0, 16'h7FFF, 16'h7FFF);
        send_vector(1'b1, 16'h8000, 16'h0000);
        send_vector(1'b0, 16'h8000, 16'h0001);
        send_vector(1'b1, 16'd100, 16'hFF9C);
        send_vector(1'b0, 16'hFF9C, 16'd100);
        // Hold off until the pipeline is empty, then restart from a cold pipeline.
        drain_results();
        send_vector(1'b1, 16'd3, 16'd4);
    endtask

    // Random vectors: a mix of full range, small (scaled) and near-axis values.
    task automatic test_random(input int count);
        logic [15:0] xr;
        logic [15:0] yr;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(2))
                0:
                begin
                    xr = 16'($urandom);
                    yr = 16'($urandom);
                end
                1:
                begin
                    xr = 16'($signed($urandom_range(508)) - 254);
                    yr = 16'($signed($urandom_range(508)) - 254);
                end
                default:
                begin
                    xr = 16'($urandom);
                    yr = 16'($signed($urandom_range(8)) - 4);
                end
            endcase
            send_vector(1'($urandom_range(1)), xr, yr);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 53;
        error_count   = 0;
        word_count    = 0;
        result_count  = 0;
        cycle_count   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(260);
        send_idle_pct = 53;
        recv_idle_pct = 28;
        test_random(260);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(260);

        drain_results();
        repeat (PIPE_LATENCY + 5) @(negedge clk);
        $display("Sent %0d vectors with both ops, checked %0d results", word_count,
                 result_count);
        $display("Covered extremes, scaling boundary, and three idle patterns");
        if (error_count == 0 && pending_polar.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
